// ----- rtl/lfu_pkg.sv -----
// shared types and constants for the lfu page replacement block
`default_nettype none

package lfu_pkg;

	localparam int PAGE_W       = 16;
	localparam int COUNT_W      = 16;
	localparam int CAP_W        = 4;
	localparam int CAPACITY_DEF = 8;

	localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
	localparam logic [COUNT_W-1:0] COUNT_FIRST = COUNT_W'(1);
	localparam logic [CAP_W-1:0]   CAP_RESET   = CAP_W'(4);

	typedef struct packed {
		logic [PAGE_W-1:0]  page;
		logic [COUNT_W-1:0] count;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MIN,
		ST_SHIFT,
		ST_APPEND,
		ST_HIT
	} lfu_state_t;

endpackage

`default_nettype wire

// ----- rtl/lfu_page_replacement.sv -----
// lfu page replacement table: top level with capacity register
// sequence: a hit scans up to the matching entry and then updates its count; a miss scans every entry,
// skipped on an empty table, then if full scans for the lowest-indexed entry with the least count,
// shifts the entries after that victim down, and appends the new page with count one
// throughput: one access at a time, set by the single read port of the table walked per entry
// reset clears the occupancy count and sets capacity to 4; table contents are not cleared
`default_nettype none

module lfu_page_replacement
	import lfu_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [CAP_W-1:0]   capacity,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [PAGE_W-1:0]  page_number,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    hit,
	output logic                    evicted,
	output logic [PAGE_W-1:0]       victim_page,
	output logic [COUNT_W-1:0]      victim_count,
	output logic [COUNT_W-1:0]      access_count
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic [CAP_W-1:0] capacity_q;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	entry_t           mem_wdata;
	logic [AW-1:0]    mem_raddr;
	entry_t           mem_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= capacity;
		end
	end

	lfu_ctrl #(
		.CAPACITY(CAPACITY),
		.AW(AW),
		.CW(CW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.capacity(capacity_q),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.page_number(page_number),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit(hit),
		.evicted(evicted),
		.victim_page(victim_page),
		.victim_count(victim_count),
		.access_count(access_count),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	lfu_table #(
		.DEPTH(CAPACITY),
		.AW(AW)
	) u_table (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

`default_nettype wire

// ----- rtl/lfu_table.sv -----
// resident page table memory, one write and one registered read per cycle
`default_nettype none

module lfu_table
	import lfu_pkg::*;
#(
	parameter int DEPTH = CAPACITY_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire entry_t        wdata,
	input  wire logic [AW-1:0] raddr,
	output entry_t             rdata
);

	entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/lfu_ctrl.sv -----
// sequencer and shared compare datapath for match scan, minimum scan and compaction
`default_nettype none

module lfu_ctrl
	import lfu_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	parameter int CW       = $clog2(CAPACITY + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [CAP_W-1:0]   capacity,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [PAGE_W-1:0]  page_number,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    hit,
	output logic                    evicted,
	output logic [PAGE_W-1:0]       victim_page,
	output logic [COUNT_W-1:0]      victim_count,
	output logic [COUNT_W-1:0]      access_count,
	output logic                    mem_we,
	output logic [AW-1:0]           mem_waddr,
	output entry_t                  mem_wdata,
	output logic [AW-1:0]           mem_raddr,
	input  wire entry_t             mem_rdata
);

	localparam int EW = (CW > CAP_W) ? CW : CAP_W;

	lfu_state_t         state_q, state_d;
	logic [PAGE_W-1:0]  page_q;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      used_q;
	logic               pend_s1;
	logic [CW-1:0]      pidx_s1;
	logic [CW-1:0]      hidx_q;
	logic [COUNT_W-1:0] hcnt_q;
	logic [CW-1:0]      vidx_q;
	entry_t             vic_q;
	logic               evict_q;
	logic               out_valid_q;

	logic               in_fire;
	logic               issue;
	logic               match;
	logic               last;
	logic               vic_upd;
	logic [CW-1:0]      vidx_fin;
	logic               shift_done;
	logic [CW-1:0]      used_m1;
	logic [CW-1:0]      pidx_m1;
	logic [EW-1:0]      cap_x;
	logic [EW-1:0]      eff_cap;
	logic               full;
	logic [COUNT_W-1:0] hcnt_inc;

	// effective capacity and occupancy test
	always_comb begin
		cap_x = EW'(capacity);
		eff_cap = cap_x;
		if (cap_x == '0) begin
			eff_cap = EW'(1);
		end
		if (cap_x > EW'(CAPACITY)) begin
			eff_cap = EW'(CAPACITY);
		end
		full = EW'(used_q) >= eff_cap;
	end

	assign in_ready   = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign in_fire    = in_valid && in_ready;
	assign used_m1    = used_q - CW'(1);
	assign pidx_m1    = pidx_s1 - CW'(1);
	assign issue      = ((state_q == ST_SCAN) || (state_q == ST_MIN) || (state_q == ST_SHIFT))
		&& (idx_q < used_q);
	assign match      = pend_s1 && (mem_rdata.page == page_q);
	assign last       = pend_s1 && (pidx_s1 == used_m1);
	assign vic_upd    = pend_s1 && ((pidx_s1 == '0) || (mem_rdata.count < vic_q.count));
	assign vidx_fin   = vic_upd ? pidx_s1 : vidx_q;
	assign shift_done = !issue && !pend_s1;
	assign hcnt_inc   = (hcnt_q == COUNT_MAX) ? COUNT_MAX : hcnt_q + COUNT_W'(1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = (used_q == '0) ? ST_APPEND : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (match) begin
					state_d = ST_HIT;
				end else if (last) begin
					state_d = full ? ST_MIN : ST_APPEND;
				end
			end
			ST_MIN: begin
				if (last) begin
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				if (shift_done) begin
					state_d = ST_APPEND;
				end
			end
			ST_APPEND: state_d = ST_IDLE;
			ST_HIT:    state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// table port controls
	always_comb begin
		mem_raddr = idx_q[AW-1:0];
		mem_we    = 1'b0;
		mem_waddr = pidx_m1[AW-1:0];
		mem_wdata = mem_rdata;
		case (state_q)
			ST_SHIFT: begin
				mem_we = pend_s1;
			end
			ST_APPEND: begin
				mem_we          = 1'b1;
				mem_waddr       = used_q[AW-1:0];
				mem_wdata.page  = page_q;
				mem_wdata.count = COUNT_FIRST;
			end
			ST_HIT: begin
				mem_we          = 1'b1;
				mem_waddr       = hidx_q[AW-1:0];
				mem_wdata.page  = page_q;
				mem_wdata.count = hcnt_inc;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= issue;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_SHIFT && shift_done) begin
				used_q <= used_m1;
			end
			if (state_q == ST_APPEND) begin
				used_q      <= used_q + CW'(1);
				out_valid_q <= 1'b1;
			end
			if (state_q == ST_HIT) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		pidx_s1 <= idx_q;
		if (issue) begin
			idx_q <= idx_q + CW'(1);
		end
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					page_q  <= page_number;
					idx_q   <= '0;
					evict_q <= 1'b0;
				end
			end
			ST_SCAN: begin
				if (match) begin
					hidx_q <= pidx_s1;
					hcnt_q <= mem_rdata.count;
				end else if (last) begin
					idx_q   <= '0;
					evict_q <= full;
				end
			end
			ST_MIN: begin
				if (vic_upd) begin
					vic_q  <= mem_rdata;
					vidx_q <= pidx_s1;
				end
				if (last) begin
					idx_q <= vidx_fin + CW'(1);
				end
			end
			ST_APPEND: begin
				hit          <= 1'b0;
				evicted      <= evict_q;
				victim_page  <= evict_q ? vic_q.page : '0;
				victim_count <= evict_q ? vic_q.count : '0;
				access_count <= COUNT_FIRST;
			end
			ST_HIT: begin
				hit          <= 1'b1;
				evicted      <= 1'b0;
				victim_page  <= '0;
				victim_count <= '0;
				access_count <= hcnt_inc;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- rtl/lfu_checker.sv -----
// port-level assertions for the lfu page replacement block and their bind
`default_nettype none

module lfu_checker
	import lfu_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic               hit,
	input wire logic               evicted,
	input wire logic [PAGE_W-1:0]  victim_page,
	input wire logic [COUNT_W-1:0] victim_count,
	input wire logic [COUNT_W-1:0] access_count
);

	// a hit never evicts
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> !evicted)
		else $error("hit reported together with eviction");

	// no eviction means zero victim fields
	a_victim_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !evicted |-> (victim_page == '0) && (victim_count == '0))
		else $error("victim fields nonzero without eviction");

	// a miss appends with count one
	a_miss_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> access_count == COUNT_FIRST)
		else $error("miss reported with count other than one");

	// one access at a time
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an access is in progress");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

endmodule

bind lfu_page_replacement lfu_checker u_lfu_checker (.*);

`default_nettype wire
